[rtl/ccs_pkg.sv]
// Types and codes shared by the clock correction scheduler.
// No dependencies.
package ccs_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned DriftW  = 8;
  localparam int unsigned OffsetW = 16;
  localparam int unsigned KindW   = 2;

  typedef enum logic {
    OP_PARAM_CHECK = 1'b0,
    OP_DAY_TICK    = 1'b1
  } op_e;

  typedef enum logic [KindW-1:0] {
    KIND_NONE   = 2'd0,
    KIND_SET    = 2'd1,
    KIND_OFFSET = 2'd2,
    KIND_DRIFT  = 2'd3
  } kind_e;

  typedef struct packed {
    op_e                       operation;
    logic [TimeW-1:0]          local_epoch;
    logic signed [DriftW-1:0]  drift_value;
    logic [DriftW-1:0]         drift_period;
    logic signed [OffsetW-1:0] offset_request;
    logic [TimeW-1:0]          epoch_request;
  } req_t;

  typedef struct packed {
    kind_e            adjust_kind;
    logic [TimeW-1:0] new_unix_time;
    logic             drift_changed;
    logic             offset_changed;
    logic             clock_changed;
    logic [TimeW-1:0] published_epoch;
  } res_t;

endpackage

[rtl/ccs_core.sv]
// Scheduler state and the combinational update for one request.
// Depends on ccs_pkg.
module ccs_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  ccs_pkg::req_t              req_i,
  input  logic [ccs_pkg::TimeW-1:0]  unix_offset_i,
  output ccs_pkg::res_t              res_o
);
  import ccs_pkg::*;

  logic signed [DriftW-1:0] drift_value_q, drift_value_d;
  logic [DriftW-1:0]        drift_period_q, drift_period_d;
  logic [DriftW-1:0]        days_left_q, days_left_d;
  logic [TimeW-1:0]         pending_value_q, pending_value_d;
  logic                     epoch_pending_q, epoch_pending_d;
  logic                     offset_pending_q, offset_pending_d;
  logic [TimeW-1:0]         last_published_q, last_published_d;

  logic signed [OffsetW-1:0] corr;
  logic [OffsetW:0]          mag;
  logic [TimeW:0]            diff;
  logic [TimeW-1:0]          applied;
  logic [DriftW-1:0]         days_dec;

  // Add a signed correction to the local epoch, clamp at zero
  always_comb begin
    corr = offset_pending_q ? $signed(pending_value_q[OffsetW-1:0])
                            : OffsetW'(drift_value_q);
    mag  = {1'b0, ~corr} + (OffsetW+1)'(1);
    diff = {1'b0, req_i.local_epoch} - {{(TimeW-OffsetW){1'b0}}, mag};
    if (corr[OffsetW-1]) begin
      applied = diff[TimeW] ? '0 : diff[TimeW-1:0];
    end else begin
      applied = req_i.local_epoch + {{(TimeW-OffsetW){1'b0}}, corr};
    end
  end

  assign days_dec = days_left_q - DriftW'(1);

  always_comb begin
    logic [TimeW-1:0] e;
    drift_value_d    = drift_value_q;
    drift_period_d   = drift_period_q;
    days_left_d      = days_left_q;
    pending_value_d  = pending_value_q;
    epoch_pending_d  = epoch_pending_q;
    offset_pending_d = offset_pending_q;
    last_published_d = last_published_q;
    res_o            = '0;
    e                = '0;
    res_o.adjust_kind = KIND_NONE;
    if (req_i.operation == OP_DAY_TICK) begin
      if (epoch_pending_q) begin
        e = pending_value_q;
        res_o.adjust_kind = KIND_SET;
      end else if (offset_pending_q) begin
        if (pending_value_q[OffsetW-1:0] != '0) begin
          e = applied;
          res_o.adjust_kind = KIND_OFFSET;
        end
      end else begin
        days_left_d = days_dec;
        if (days_dec == '0) begin
          days_left_d = drift_period_q;
          if (drift_value_q != '0) begin
            e = applied;
            res_o.adjust_kind = KIND_DRIFT;
          end
        end
      end
      res_o.new_unix_time = (e != '0) ? unix_offset_i + e : '0;
      pending_value_d  = '0;
      epoch_pending_d  = 1'b0;
      offset_pending_d = 1'b0;
      last_published_d = '0;
    end else begin
      if (req_i.drift_value != drift_value_q || req_i.drift_period != drift_period_q) begin
        drift_value_d  = req_i.drift_value;
        drift_period_d = req_i.drift_period;
        days_left_d    = req_i.drift_period;
        res_o.drift_changed = 1'b1;
      end
      if (req_i.offset_request != '0) begin
        pending_value_d  = {{(TimeW-OffsetW){1'b0}}, req_i.offset_request};
        offset_pending_d = 1'b1;
        epoch_pending_d  = 1'b0;
        res_o.offset_changed = 1'b1;
      end
      if (last_published_q != '0 && req_i.epoch_request != last_published_q) begin
        pending_value_d  = req_i.epoch_request;
        epoch_pending_d  = 1'b1;
        offset_pending_d = 1'b0;
        res_o.clock_changed = 1'b1;
      end
      last_published_d      = req_i.local_epoch;
      res_o.published_epoch = req_i.local_epoch;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drift_value_q    <= '0;
      drift_period_q   <= '0;
      days_left_q      <= '0;
      pending_value_q  <= '0;
      epoch_pending_q  <= 1'b0;
      offset_pending_q <= 1'b0;
      last_published_q <= '0;
    end else if (fire_i) begin
      drift_value_q    <= drift_value_d;
      drift_period_q   <= drift_period_d;
      days_left_q      <= days_left_d;
      pending_value_q  <= pending_value_d;
      epoch_pending_q  <= epoch_pending_d;
      offset_pending_q <= offset_pending_d;
      last_published_q <= last_published_d;
    end
  end

  a_pending_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(epoch_pending_q && offset_pending_q))
    else $error("epoch and offset both pending");

  a_tick_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && req_i.operation == OP_DAY_TICK |=>
      !epoch_pending_q && !offset_pending_q && last_published_q == '0)
    else $error("day tick left pending state");

  a_set_needs_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.adjust_kind == KIND_SET |-> epoch_pending_q)
    else $error("absolute set without pending epoch");

endmodule

[rtl/clock_correction_scheduler.sv]
// Clock correction scheduler: request register, ccs_core update, result register.
// Depends on ccs_pkg and ccs_core.
//
// Usage:
//   Requests enter on in_valid_i/in_ready_o with one port per field;
//   operation_i selects a parameter check or a day tick. Every request
//   gives exactly one result on out_valid_o/out_ready_i.
//   unix_offset is written through cfg_we_i/cfg_wdata_i; the user must write
//   it only while idle, which the block does not enforce. A request passes
//   through the request register, then the result register, to its result.
//   Throughput: one request per cycle while results are taken; the scheduler
//   state updates when a request moves on into the result register.
//   Reset clears all scheduler state and unix_offset to zero and empties
//   both registers.
//   When the receiver stalls, the result register holds; the request
//   register still takes one more request, then in_ready_o drops until
//   the result is taken.
module clock_correction_scheduler (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ccs_pkg::TimeW-1:0]          cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               operation_i,
  input  logic [ccs_pkg::TimeW-1:0]          unix_time_i,
  input  logic signed [ccs_pkg::DriftW-1:0]  drift_value_i,
  input  logic [ccs_pkg::DriftW-1:0]         drift_period_i,
  input  logic signed [ccs_pkg::OffsetW-1:0] offset_request_i,
  input  logic [ccs_pkg::TimeW-1:0]          epoch_request_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [ccs_pkg::KindW-1:0]          adjust_kind_o,
  output logic [ccs_pkg::TimeW-1:0]          new_unix_time_o,
  output logic                               drift_changed_o,
  output logic                               offset_changed_o,
  output logic                               clock_changed_o,
  output logic [ccs_pkg::TimeW-1:0]          published_epoch_o
);
  import ccs_pkg::*;

  logic [TimeW-1:0] unix_offset_q;
  logic             req_valid_q;
  req_t             req_q, req_d;
  logic             out_valid_q;
  res_t             res_q, res_d;
  logic             advance;
  logic             fire;

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = req_valid_q && advance;
  assign in_ready_o = !req_valid_q || advance;

  always_comb begin
    req_d.operation      = op_e'(operation_i);
    req_d.local_epoch    = unix_time_i - unix_offset_q;
    req_d.drift_value    = drift_value_i;
    req_d.drift_period   = drift_period_i;
    req_d.offset_request = offset_request_i;
    req_d.epoch_request  = epoch_request_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unix_offset_q <= '0;
    end else if (cfg_we_i) begin
      unix_offset_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        req_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= req_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= req_d;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  ccs_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .req_i         (req_q),
    .unix_offset_i (unix_offset_q),
    .res_o         (res_d)
  );

  assign out_valid_o       = out_valid_q;
  assign adjust_kind_o     = res_q.adjust_kind;
  assign new_unix_time_o   = res_q.new_unix_time;
  assign drift_changed_o   = res_q.drift_changed;
  assign offset_changed_o  = res_q.offset_changed;
  assign clock_changed_o   = res_q.clock_changed;
  assign published_epoch_o = res_q.published_epoch;

  a_check_no_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (drift_changed_o || offset_changed_o || clock_changed_o) |->
      adjust_kind_o == KIND_NONE && new_unix_time_o == '0)
    else $error("parameter check result carries a clock load");

  a_none_no_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && adjust_kind_o == KIND_NONE |-> new_unix_time_o == '0)
    else $error("clock load without adjustment kind");

  a_result_follows_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("processed request produced no result");

endmodule

[tb/tb_clock_correction_scheduler.sv]
// Self-checking testbench for clock_correction_scheduler: directed and random requests,
// predicted in-bench and compared against every result under varied handshake idling.
// Depends on ccs_pkg and the clock_correction_scheduler RTL.
`timescale 1ns / 100ps

module tb_clock_correction_scheduler;
  import ccs_pkg::*;

  typedef struct packed {
    op_e                operation;
    logic [31:0]        unix_time;
    logic signed [7:0]  drift_value;
    logic [7:0]         drift_period;
    logic signed [15:0] offset_request;
    logic [31:0]        epoch_request;
  } clk_req_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [31:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               operation_i = 1'b0;
  logic [31:0]        unix_time_i = '0;
  logic signed [7:0]  drift_value_i = '0;
  logic [7:0]         drift_period_i = '0;
  logic signed [15:0] offset_request_i = '0;
  logic [31:0]        epoch_request_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         adjust_kind_o;
  logic [31:0]        new_unix_time_o;
  logic               drift_changed_o;
  logic               offset_changed_o;
  logic               clock_changed_o;
  logic [31:0]        published_epoch_o;

  logic [31:0]       sched_unix_offset = '0;
  logic signed [7:0] sched_drift_val = '0;
  logic [7:0]        sched_drift_per = '0;
  logic [7:0]        sched_days_left = '0;
  logic [31:0]       sched_pending = '0;
  logic              sched_epoch_pend = 1'b0;
  logic              sched_offset_pend = 1'b0;
  logic [31:0]       sched_last_pub = '0;

  res_t        expected_results[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int          hold_off_cycles = 0;

  clock_correction_scheduler u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .unix_time_i      (unix_time_i),
    .drift_value_i    (drift_value_i),
    .drift_period_i   (drift_period_i),
    .offset_request_i (offset_request_i),
    .epoch_request_i  (epoch_request_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .adjust_kind_o    (adjust_kind_o),
    .new_unix_time_o  (new_unix_time_o),
    .drift_changed_o  (drift_changed_o),
    .offset_changed_o (offset_changed_o),
    .clock_changed_o  (clock_changed_o),
    .published_epoch_o(published_epoch_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [31:0] add_clamped(logic [31:0] base, int corr);
    logic [31:0] mag;
    if (corr < 0) begin
      mag = -corr;
      return (base < mag) ? 32'd0 : base - mag;
    end
    return base + corr;
  endfunction

  function automatic res_t predict_correction(clk_req_t r);
    res_t        e;
    logic [31:0] local_ep;
    logic [31:0] corrected;
    e = '0;
    corrected = '0;
    local_ep = r.unix_time - sched_unix_offset;
    if (r.operation == OP_DAY_TICK) begin
      if (sched_epoch_pend) begin
        corrected = sched_pending;
        e.adjust_kind = KIND_SET;
      end else if (sched_offset_pend) begin
        if (sched_pending[15:0] != 16'd0) begin
          corrected = add_clamped(local_ep, int'($signed(sched_pending[15:0])));
          e.adjust_kind = KIND_OFFSET;
        end
      end else begin
        sched_days_left = sched_days_left - 8'd1;
        if (sched_days_left == 8'd0) begin
          sched_days_left = sched_drift_per;
          if (sched_drift_val != 8'sd0) begin
            corrected = add_clamped(local_ep, int'(sched_drift_val));
            e.adjust_kind = KIND_DRIFT;
          end
        end
      end
      sched_pending = '0;
      sched_epoch_pend = 1'b0;
      sched_offset_pend = 1'b0;
      e.new_unix_time = (corrected != 32'd0) ? sched_unix_offset + corrected : 32'd0;
      sched_last_pub = '0;
    end else begin
      if (r.drift_value != sched_drift_val || r.drift_period != sched_drift_per) begin
        sched_drift_val = r.drift_value;
        sched_drift_per = r.drift_period;
        sched_days_left = r.drift_period;
        e.drift_changed = 1'b1;
      end
      if (r.offset_request != 16'sd0) begin
        sched_pending = {16'd0, r.offset_request};
        sched_offset_pend = 1'b1;
        sched_epoch_pend = 1'b0;
        e.offset_changed = 1'b1;
      end
      if (sched_last_pub != 32'd0 && r.epoch_request != sched_last_pub) begin
        sched_pending = r.epoch_request;
        sched_epoch_pend = 1'b1;
        sched_offset_pend = 1'b0;
        e.clock_changed = 1'b1;
      end
      sched_last_pub = local_ep;
      e.published_epoch = local_ep;
    end
    return e;
  endfunction

  function automatic clk_req_t random_request();
    clk_req_t r;
    r.operation = op_e'($urandom_range(1));
    r.unix_time = $urandom;
    r.drift_value = 8'($urandom);
    r.drift_period = 8'($urandom);
    r.offset_request = 16'($urandom);
    r.epoch_request = $urandom;
    return r;
  endfunction

  function automatic logic [31:0] pick_time();
    case ($urandom_range(9))
      0: return 32'hFFFF_FFFF;
      1: return sched_unix_offset - 32'd1;
      2, 3, 4: return sched_unix_offset + $urandom_range(200);
      default: return $urandom;
    endcase
  endfunction

  function automatic void report_mismatch(string what, res_t want);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected kind=%0d time=%h chg=%b%b%b pub=%h", $realtime, what,
               want.adjust_kind, want.new_unix_time, want.drift_changed,
               want.offset_changed, want.clock_changed, want.published_epoch);
      $display("%0t %s:      got kind=%0d time=%h chg=%b%b%b pub=%h", $realtime, what,
               adjust_kind_o, new_unix_time_o, drift_changed_o, offset_changed_o,
               clock_changed_o, published_epoch_o);
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", '0);
      end else begin
        want = expected_results.pop_front();
        if (adjust_kind_o !== want.adjust_kind || new_unix_time_o !== want.new_unix_time ||
            drift_changed_o !== want.drift_changed ||
            offset_changed_o !== want.offset_changed ||
            clock_changed_o !== want.clock_changed ||
            published_epoch_o !== want.published_epoch) begin
          report_mismatch("result mismatch", want);
        end
      end
    end
  end

  // hold off for the requested stretch, else stall at random
  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      out_ready_i = 1'b0;
      hold_off_cycles--;
    end else begin
      out_ready_i = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_request(input clk_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    operation_i = r.operation;
    unix_time_i = r.unix_time;
    drift_value_i = r.drift_value;
    drift_period_i = r.drift_period;
    offset_request_i = r.offset_request;
    epoch_request_i = r.epoch_request;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(predict_correction(r));
    @(negedge clk_i);
  endtask

  task automatic send_check(input logic [31:0] utime, input logic signed [7:0] dval,
                            input logic [7:0] dper, input logic signed [15:0] offr,
                            input logic [31:0] epr);
    clk_req_t r;
    r.operation = OP_PARAM_CHECK;
    r.unix_time = utime;
    r.drift_value = dval;
    r.drift_period = dper;
    r.offset_request = offr;
    r.epoch_request = epr;
    send_request(r);
  endtask

  task automatic send_tick(input logic [31:0] utime);
    clk_req_t r;
    r = random_request();
    r.operation = OP_DAY_TICK;
    r.unix_time = utime;
    send_request(r);
  endtask

  task automatic await_results();
    in_valid_i = 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_unix_offset(input logic [31:0] value);
    await_results();
    cfg_wdata_i = value;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sched_unix_offset = value;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic test_reset_state();
    send_tick(32'd1000);
    send_check(32'd1000, 8'sd0, 8'd0, 16'sd0, 32'hDEAD_BEEF);
    send_check(32'd2000, 8'sd0, 8'd0, 16'sd0, 32'd1000);
  endtask

  task automatic test_drift_update();
    send_check(32'd3000, 8'sd5, 8'd0, 16'sd0, sched_last_pub);
    send_check(32'd3001, 8'sd5, 8'd1, 16'sd0, sched_last_pub);
    send_check(32'd3002, 8'sd5, 8'd1, 16'sd0, sched_last_pub);
    send_tick(32'd4000);
    send_check(32'd10, -8'sd128, 8'd1, 16'sd0, 32'd0);
    send_tick(32'd10);
    send_check(32'd20, 8'sd127, 8'd1, 16'sd0, 32'd0);
    send_tick(32'hFFFF_FFF0);
    send_check(32'd0, 8'sd0, 8'd1, 16'sd0, 32'd0);
    send_tick(32'd50);
  endtask

  task automatic test_offset_and_epoch();
    send_check(32'd100, 8'sd0, 8'd1, 16'sd300, 32'd0);
    send_tick(32'd100);
    send_check(32'd100, 8'sd0, 8'd1, -16'sd32768, 32'd0);
    send_tick(32'd40000);
    send_check(32'd100, 8'sd0, 8'd1, -16'sd32768, 32'd0);
    send_tick(32'd5);
    send_check(32'd500, 8'sd0, 8'd1, 16'sd32767, 32'd0);
    send_check(32'd600, 8'sd0, 8'd1, 16'sd7, 32'd12345);
    send_tick(32'd600);
    send_check(32'd700, 8'sd0, 8'd1, 16'sd0, 32'd0);
    send_check(32'd800, 8'sd0, 8'd1, 16'sd0, 32'd0);
    send_tick(32'd800);
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned       sent;
    int unsigned       n_ticks;
    logic signed [7:0] dval;
    logic [7:0]        dper;
    logic signed [15:0] offr;
    logic [31:0]       epr;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(99)) inside
        [0:14]: begin
          send_request(random_request());
          sent++;
        end
        [15:74]: begin
          if ($urandom_range(9) < 7) begin
            dval = sched_drift_val;
            dper = sched_drift_per;
          end else begin
            dval = 8'($urandom);
            dper = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 4));
          end
          case ($urandom_range(3))
            2: offr = 16'($urandom);
            3: begin
              case ($urandom_range(3))
                0: offr = -16'sd32768;
                1: offr = 16'sd32767;
                2: offr = -16'sd1;
                default: offr = 16'sd1;
              endcase
            end
            default: offr = 16'sd0;
          endcase
          case ($urandom_range(9))
            0: epr = 32'd0;
            1, 2, 3: epr = $urandom;
            default: epr = sched_last_pub;
          endcase
          send_check(pick_time(), dval, dper, offr, epr);
          n_ticks = $urandom_range(4);
          repeat (n_ticks) send_tick(pick_time());
          sent += 1 + n_ticks;
        end
        default: begin
          n_ticks = $urandom_range(1, 8);
          repeat (n_ticks) send_tick(pick_time());
          sent += n_ticks;
        end
      endcase
    end
  endtask

  task automatic test_backpressure();
    hold_off_cycles = 60;
    repeat (20) send_request(random_request());
    await_results();
  endtask

  // period zero reloads zero, so the drift lands every 256 days
  task automatic test_long_drift_period();
    logic signed [7:0] dval;
    send_tick(pick_time());
    dval = (sched_drift_val == -8'sd77) ? 8'sd77 : -8'sd77;
    send_check(pick_time(), dval, 8'd0, 16'sd0, 32'd0);
    repeat (513) send_tick(pick_time());
    await_results();
  endtask

  initial begin : run_tests
    int unsigned drain_cycles;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_drift_update();
    test_offset_and_epoch();

    write_unix_offset(32'hFFFF_FFFF);
    set_idling(0, 0);
    test_random_traffic(100);
    write_unix_offset($urandom);
    set_idling(77, 0);
    test_random_traffic(100);
    write_unix_offset(32'd0);
    set_idling(0, 77);
    test_random_traffic(100);
    write_unix_offset(32'h8000_0000);
    set_idling(19, 19);
    test_random_traffic(100);

    set_idling(0, 0);
    test_backpressure();
    write_unix_offset($urandom);
    test_long_drift_period();

    in_valid_i = 1'b0;
    drain_cycles = 0;
    while (expected_results.size() != 0 && drain_cycles < 10000) begin
      @(negedge clk_i);
      drain_cycles++;
    end
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

[clock_correction_scheduler.f]
rtl/ccs_pkg.sv
rtl/ccs_core.sv
rtl/clock_correction_scheduler.sv
tb/tb_clock_correction_scheduler.sv
